// ===== design/cedf_pkg.sv =====
package cedf_pkg;

  // Lengths of the little-endian fields, in bytes.
  localparam int COUNT_BYTES = 4;
  localparam int TIME_BYTES  = 8;
  localparam int LEN_BYTES   = 4;

  // Lowest format version that puts a tag byte before each event.
  localparam int TAGGED_VERSION = 2;

  // Event tag codes.
  localparam logic [7:0] TAG_RECORD    = 8'd0;
  localparam logic [7:0] TAG_WATERMARK = 8'd1;
  localparam logic [7:0] TAG_CLOCK     = 8'd2;

  typedef enum logic [3:0] {
    PH_COUNT = 4'd0,
    PH_TAG   = 4'd1,
    PH_FLAG  = 4'd2,
    PH_RTIME = 4'd3,
    PH_RLEN  = 4'd4,
    PH_VALUE = 4'd5,
    PH_WTIME = 4'd6,
    PH_WIDLE = 4'd7,
    PH_CTIME = 4'd8,
    PH_DONE  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    KIND_VALUE     = 3'd0,
    KIND_HEADER    = 3'd1,
    KIND_WATERMARK = 3'd2,
    KIND_CLOCK     = 3'd3,
    KIND_BAD_TAG   = 3'd4,
    KIND_TRUNC     = 3'd5,
    KIND_END       = 3'd6
  } event_kind_t;

  // One buffered input beat.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       final_byte;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    event_kind_t        event_kind;
    logic [7:0]         value_byte;
    logic               time_present;
    logic signed [63:0] time_stamp;
    logic               idle_mark;
    logic [31:0]        value_length;
    logic               payload_done;
  } result_t;

endpackage

// ===== design/cedf_in_stage.sv =====
module cedf_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_payload_byte,
  input  logic              in_final_byte,
  input  logic              pull,
  output logic              beat_valid,
  output cedf_pkg::in_beat_t beat
);
  import cedf_pkg::*;

  logic     valid_r;
  in_beat_t beat_r;

  // The register can take a new beat when it is empty or being drained.
  assign in_ready   = !valid_r || pull;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (pull) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r.payload_byte <= in_payload_byte;
      beat_r.final_byte   <= in_final_byte;
    end
  end

endmodule

// ===== design/cedf_parser.sv =====
module cedf_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  cedf_pkg::in_beat_t beat,
  input  logic [1:0]         format_version,
  output logic               res_valid,
  output cedf_pkg::result_t  res
);
  import cedf_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic [31:0] records_r, records_nxt;
  logic [31:0] vleft_r, vleft_nxt;
  logic        pend_r, pend_nxt;
  logic [63:0] saved_r, saved_nxt;

  logic [63:0] shifted;
  logic        full4;
  logic        full8;
  logic        boundary;
  logic [7:0]  b;
  logic [31:0] rec_dec;
  logic [31:0] vleft_dec;

  // Phase that opens the next event, or the idle phase once all are seen.
  function automatic phase_t begin_phase(input logic [31:0] left, input logic [1:0] ver);
    phase_t ph;
    if (left == 32'd0) begin
      ph = PH_DONE;
    end else if (ver >= 2'(TAGGED_VERSION)) begin
      ph = PH_TAG;
    end else begin
      ph = PH_FLAG;
    end
    return ph;
  endfunction

  always_comb begin
    b         = beat.payload_byte;
    shifted   = shift_r;
    shifted[{idx_r, 3'b000} +: 8] = shift_r[{idx_r, 3'b000} +: 8] | b;
    full4     = ({1'b0, idx_r} + 4'd1) >= 4'(COUNT_BYTES);
    full8     = ({1'b0, idx_r} + 4'd1) >= 4'(TIME_BYTES);
    rec_dec   = records_r - 32'd1;
    vleft_dec = vleft_r - 32'd1;

    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    shift_nxt   = shift_r;
    records_nxt = records_r;
    vleft_nxt   = vleft_r;
    pend_nxt    = pend_r;
    saved_nxt   = saved_r;
    res         = '0;
    res_valid   = 1'b0;
    boundary    = 1'b0;

    unique case (phase_r)
      PH_COUNT: begin
        shift_nxt = shifted;
        idx_nxt   = idx_r + 3'd1;
        if (full4) begin
          idx_nxt     = '0;
          shift_nxt   = '0;
          records_nxt = shifted[31:0];
          phase_nxt   = begin_phase(shifted[31:0], format_version);
          boundary    = 1'b1;
        end
      end
      PH_TAG: begin
        case (b)
          TAG_RECORD:    phase_nxt = PH_FLAG;
          TAG_WATERMARK: phase_nxt = PH_WTIME;
          TAG_CLOCK:     phase_nxt = PH_CTIME;
          default: begin
            res.event_kind = KIND_BAD_TAG;
            res_valid      = 1'b1;
            phase_nxt      = PH_DONE;
            boundary       = 1'b1;
          end
        endcase
      end
      PH_FLAG: begin
        pend_nxt  = (b != 8'd0);
        saved_nxt = '0;
        phase_nxt = (b != 8'd0) ? PH_RTIME : PH_RLEN;
      end
      PH_RTIME, PH_WTIME: begin
        shift_nxt = shifted;
        idx_nxt   = idx_r + 3'd1;
        if (full8) begin
          idx_nxt   = '0;
          shift_nxt = '0;
          saved_nxt = shifted;
          phase_nxt = (phase_r == PH_RTIME) ? PH_RLEN : PH_WIDLE;
        end
      end
      PH_RLEN: begin
        shift_nxt = shifted;
        idx_nxt   = idx_r + 3'd1;
        if (full4) begin
          idx_nxt            = '0;
          shift_nxt          = '0;
          vleft_nxt          = shifted[31:0];
          res.event_kind     = KIND_HEADER;
          res.time_present   = pend_r;
          res.time_stamp     = pend_r ? saved_r : 64'd0;
          res.value_length   = shifted[31:0];
          res_valid          = 1'b1;
          if (shifted[31:0] == 32'd0) begin
            records_nxt = rec_dec;
            phase_nxt   = begin_phase(rec_dec, format_version);
            boundary    = 1'b1;
          end else begin
            phase_nxt = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        res.event_kind = KIND_VALUE;
        res.value_byte = b;
        res_valid      = 1'b1;
        vleft_nxt      = vleft_dec;
        if (vleft_dec == 32'd0) begin
          records_nxt = rec_dec;
          idx_nxt     = '0;
          shift_nxt   = '0;
          phase_nxt   = begin_phase(rec_dec, format_version);
          boundary    = 1'b1;
        end
      end
      PH_WIDLE: begin
        res.event_kind = KIND_WATERMARK;
        res.time_stamp = saved_r;
        res.idle_mark  = (b != 8'd0);
        res_valid      = 1'b1;
        records_nxt    = rec_dec;
        idx_nxt        = '0;
        shift_nxt      = '0;
        phase_nxt      = begin_phase(rec_dec, format_version);
        boundary       = 1'b1;
      end
      PH_CTIME: begin
        shift_nxt = shifted;
        idx_nxt   = idx_r + 3'd1;
        if (full8) begin
          res.event_kind = KIND_CLOCK;
          res.time_stamp = shifted;
          res_valid      = 1'b1;
          records_nxt    = rec_dec;
          idx_nxt        = '0;
          shift_nxt      = '0;
          phase_nxt      = begin_phase(rec_dec, format_version);
          boundary       = 1'b1;
        end
      end
      default: begin
        boundary = 1'b1;
      end
    endcase

    // The last byte closes the payload: a cut-off event reports truncation,
    // and the parse state starts over for the next payload.
    if (beat.final_byte) begin
      if (!boundary) begin
        res            = '0;
        res.event_kind = (phase_r == PH_COUNT) ? KIND_END : KIND_TRUNC;
        res_valid      = 1'b1;
      end else if (!res_valid) begin
        res            = '0;
        res.event_kind = KIND_END;
        res_valid      = 1'b1;
      end
      res.payload_done = 1'b1;
      phase_nxt   = PH_COUNT;
      idx_nxt     = '0;
      shift_nxt   = '0;
      records_nxt = '0;
      vleft_nxt   = '0;
      pend_nxt    = 1'b0;
      saved_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_COUNT;
      idx_r     <= '0;
      shift_r   <= '0;
      records_r <= '0;
      vleft_r   <= '0;
      pend_r    <= 1'b0;
      saved_r   <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      shift_r   <= shift_nxt;
      records_r <= records_nxt;
      vleft_r   <= vleft_nxt;
      pend_r    <= pend_nxt;
      saved_r   <= saved_nxt;
    end
  end

endmodule

// ===== design/cedf_out_stage.sv =====
module cedf_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  cedf_pkg::result_t res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output cedf_pkg::result_t out_res
);
  import cedf_pkg::*;

  logic    valid_r;
  result_t res_r;

  // Room for a new result when empty or when the held one leaves this cycle.
  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== design/capture_event_deframer.sv =====
// Capture event deframer.
// The input channel (in_valid / in_ready) carries one payload byte per beat,
// with in_final_byte set on the last byte of a payload. The result channel
// (out_valid / out_ready) carries at most one result beat per input beat:
// a value byte, a record header, a watermark, a clock, an unknown tag, a
// truncation or a bare end-of-payload marker.
// The cfg channel (cfg_valid / cfg_ready) writes the format version; it is
// always ready and is meant to be written only while the block is idle.
// Each byte taken is held in the input register and parsed, and its result is
// registered in the result register, from which it leaves on the result channel.
// Throughput: one byte per cycle, sustained while out_ready stays high. Every byte
// is parsed combinationally between the input register and the result register;
// the parse state (phase, field shifter, record and byte counters) updates once per byte.
// Reset sets the format version to 2 and returns the parser to reading the
// record count; both beat registers come up empty.
// When the receiver stalls, the result register holds its beat, the parser
// stops, the input register keeps one byte and in_ready drops after that.
module capture_event_deframer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_payload_byte,
  input  logic               in_final_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_event_kind,
  output logic [7:0]         out_value_byte,
  output logic               out_time_present,
  output logic signed [63:0] out_time_stamp,
  output logic               out_idle_mark,
  output logic [31:0]        out_value_length,
  output logic               out_payload_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_format_version
);
  import cedf_pkg::*;

  logic       fmt_ver_r;
  logic [1:0] format_version_r;
  logic       beat_valid;
  in_beat_t   beat;
  logic       room;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // The version register takes every write; nothing else is configurable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_version_r <= 2'(TAGGED_VERSION);
      fmt_ver_r        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      format_version_r <= cfg_format_version;
      fmt_ver_r        <= 1'b1;
    end
  end

  // A buffered byte is parsed whenever the result register has room for
  // whatever it produces.
  assign step = beat_valid && room;

  cedf_in_stage u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_byte (in_payload_byte),
    .in_final_byte   (in_final_byte),
    .pull            (step),
    .beat_valid      (beat_valid),
    .beat            (beat)
  );

  cedf_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .beat           (beat),
    .format_version (format_version_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  cedf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_event_kind   = out_res.event_kind;
  assign out_value_byte   = out_res.value_byte;
  assign out_time_present = out_res.time_present;
  assign out_time_stamp   = out_res.time_stamp;
  assign out_idle_mark    = out_res.idle_mark;
  assign out_value_length = out_res.value_length;
  assign out_payload_done = out_res.payload_done;

  // A stalled result is never overwritten by a newly parsed byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(step && out_valid && !out_ready))
    else $error("parser advanced into a stalled result register");

  // Truncation and end markers only ever close a payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == KIND_TRUNC || out_event_kind == KIND_END)
    |-> out_payload_done)
    else $error("end or truncation result without payload_done");

  // A value byte is carried only on value results.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != KIND_VALUE |-> out_value_byte == 8'd0)
    else $error("value byte set on a non-value result");

  // The time flag belongs to record headers only.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_time_present |-> out_event_kind == KIND_HEADER)
    else $error("time_present set outside a record header");

  // After a version write the stored version matches the written data.
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> fmt_ver_r && format_version_r == $past(cfg_format_version))
    else $error("format version write lost");

endmodule
